// ===== src/mrde_pkg.sv =====
// Shared types, codes and index helpers of the message ring descriptor engine.
// Used by every module under src; depends on nothing.
package mrde_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = 5;
  localparam int CAP_W       = IDX_W + 1;
  localparam int CLIENT_W    = 6;
  localparam int FLAG_W      = 4;

  localparam int F_PEND = 0;
  localparam int F_SYNC = 1;
  localparam int F_COMP = 2;
  localparam int F_ERR  = 3;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [CLIENT_W-1:0] client_t;
  typedef logic [FLAG_W-1:0]   flags_t;

  typedef enum logic [1:0] {
    MODE_PRODUCE, MODE_CONSUME, MODE_RECLAIM, MODE_FINISH
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK, STAT_FULL, STAT_FILL_FAILED, STAT_EMPTY,
    STAT_NOT_PENDING, STAT_STILL_PENDING, STAT_WAKE, STAT_TAIL
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EXEC, S_SCAN, S_FIX
  } state_t;

  typedef struct packed {
    logic    en;
    idx_t    addr;
    flags_t  flags;
    logic    client_en;
    client_t client;
  } wr_req_t;

  typedef struct packed {
    flags_t  flags;
    logic    write;
    status_t status;
    logic    sync;
    logic    err;
    logic    wake;
  } alu_res_t;

  function automatic cap_t active_cap(cap_t c);
    cap_t r;
    r = c;
    if (c < cap_t'(2)) r = cap_t'(2);
    if (c > cap_t'(MAX_ENTRIES)) r = cap_t'(MAX_ENTRIES);
    return r;
  endfunction

  function automatic idx_t next_idx(idx_t i, cap_t cap);
    cap_t s;
    s = {1'b0, i} + cap_t'(1);
    return (s >= cap) ? '0 : s[IDX_W-1:0];
  endfunction

endpackage

// ===== src/mrde_flag_store.sv =====
// Per-entry flag bank (cleared by reset) and client bank of the ring.
// One read address, one write request per cycle; uses mrde_pkg.
module mrde_flag_store (
  input  logic              clk,
  input  logic              rst_n,
  input  mrde_pkg::idx_t    rd_addr,
  output mrde_pkg::flags_t  rd_flags,
  output mrde_pkg::client_t rd_client,
  input  mrde_pkg::wr_req_t wr
);

  mrde_pkg::flags_t  flags_r  [mrde_pkg::MAX_ENTRIES];
  mrde_pkg::client_t client_r [mrde_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '{default: '0};
    end else if (wr.en) begin
      flags_r[wr.addr] <= wr.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.client_en) begin
      client_r[wr.addr] <= wr.client;
    end
  end

  assign rd_flags  = flags_r[rd_addr];
  assign rd_client = client_r[rd_addr];

endmodule

// ===== src/mrde_flag_alu.sv =====
// Shared flag update unit: next flags and status of one entry for each request kind.
// Purely combinational; uses mrde_pkg.
module mrde_flag_alu (
  input  mrde_pkg::mode_t    op,
  input  mrde_pkg::flags_t   f,
  input  logic               sync_req,
  output mrde_pkg::alu_res_t res
);

  mrde_pkg::flags_t g;

  always_comb begin
    g   = f;
    res = '0;
    res.status = mrde_pkg::STAT_OK;
    res.sync   = f[mrde_pkg::F_SYNC];
    res.err    = f[mrde_pkg::F_ERR];
    case (op)
      mrde_pkg::MODE_PRODUCE: begin
        g = '0;
        g[mrde_pkg::F_PEND] = 1'b1;
        g[mrde_pkg::F_SYNC] = sync_req;
        g[mrde_pkg::F_COMP] = !sync_req;
        res.write = 1'b1;
        res.sync  = sync_req;
      end
      mrde_pkg::MODE_CONSUME: begin
        if (f[mrde_pkg::F_PEND]) begin
          g[mrde_pkg::F_PEND] = 1'b0;
          res.write = 1'b1;
        end else begin
          res.status = mrde_pkg::STAT_NOT_PENDING;
        end
      end
      mrde_pkg::MODE_RECLAIM: begin
        if (f[mrde_pkg::F_PEND]) begin
          g[mrde_pkg::F_PEND] = 1'b0;
          g[mrde_pkg::F_ERR]  = 1'b1;
        end
        if (!f[mrde_pkg::F_COMP]) begin
          if (f[mrde_pkg::F_SYNC]) begin
            res.wake   = 1'b1;
            res.status = mrde_pkg::STAT_WAKE;
          end else begin
            g[mrde_pkg::F_COMP] = 1'b1;
          end
        end
        res.write = 1'b1;
      end
      mrde_pkg::MODE_FINISH: begin
        if (f[mrde_pkg::F_PEND]) begin
          res.status = mrde_pkg::STAT_STILL_PENDING;
        end else begin
          g[mrde_pkg::F_COMP] = 1'b1;
          res.write = 1'b1;
        end
      end
      default: begin
        g = f;
      end
    endcase
    res.flags = g;
  end

endmodule

// ===== src/mrde_seq.sv =====
// Request sequencer: ring indices, capacity register, reclaim walk and result register.
// Drives the flag store and the shared flag unit; uses mrde_pkg.
module mrde_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_mode,
  input  logic [5:0]                in_client_id,
  input  logic                      in_sync_request,
  input  logic                      in_fill_failed,
  input  logic [4:0]                in_slot,
  input  logic                      cfg_we,
  input  logic [5:0]                cfg_wdata,
  output mrde_pkg::idx_t            rd_addr,
  input  mrde_pkg::client_t         rd_client,
  output mrde_pkg::mode_t           alu_op,
  output logic                      alu_sync,
  input  mrde_pkg::alu_res_t        alu,
  output mrde_pkg::wr_req_t         wr,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [4:0]                out_entry_index,
  output logic [5:0]                out_wake_client,
  output logic                      out_notify_peer,
  output logic                      out_sync_flag,
  output logic                      out_entry_error,
  output logic [4:0]                out_new_tail,
  output logic                      out_last
);

  mrde_pkg::state_t  state_r, state_nxt;
  mrde_pkg::mode_t   mode_r, mode_nxt;
  mrde_pkg::client_t client_r, client_nxt;
  logic              sync_r, sync_nxt;
  logic              fail_r, fail_nxt;
  mrde_pkg::idx_t    slot_r, slot_nxt;
  mrde_pkg::cap_t    cap_r, cap_nxt;
  mrde_pkg::idx_t    prod_r, prod_nxt;
  mrde_pkg::idx_t    cons_r, cons_nxt;
  mrde_pkg::idx_t    tail_r, tail_nxt;
  mrde_pkg::idx_t    walk_r, walk_nxt;
  mrde_pkg::idx_t    stop_r, stop_nxt;

  logic              ov_r, ov_nxt;
  mrde_pkg::status_t ostat_r, ostat_nxt;
  mrde_pkg::idx_t    oidx_r, oidx_nxt;
  mrde_pkg::client_t owake_r, owake_nxt;
  logic              onotify_r, onotify_nxt;
  logic              osync_r, osync_nxt;
  logic              oerr_r, oerr_nxt;
  mrde_pkg::idx_t    otail_r, otail_nxt;
  logic              olast_r, olast_nxt;

  mrde_pkg::cap_t    cap_act;
  mrde_pkg::idx_t    prod_adv;
  logic              walk_done;

  assign cap_act   = mrde_pkg::active_cap(cap_r);
  assign prod_adv  = mrde_pkg::next_idx(prod_r, cap_act);
  assign walk_done = (walk_r == cons_r);
  assign busy      = (state_r != mrde_pkg::S_IDLE);
  assign alu_sync  = sync_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrde_pkg::S_IDLE: begin
        if (start && !cfg_we) begin
          state_nxt = (mrde_pkg::mode_t'(in_mode) == mrde_pkg::MODE_RECLAIM) ?
                      mrde_pkg::S_SCAN : mrde_pkg::S_EXEC;
        end
      end
      mrde_pkg::S_EXEC: state_nxt = mrde_pkg::S_IDLE;
      mrde_pkg::S_SCAN: begin
        if (walk_done || alu.wake) state_nxt = mrde_pkg::S_FIX;
      end
      mrde_pkg::S_FIX: begin
        if (walk_done) state_nxt = mrde_pkg::S_IDLE;
      end
      default: state_nxt = mrde_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt    = mode_r;
    client_nxt  = client_r;
    sync_nxt    = sync_r;
    fail_nxt    = fail_r;
    slot_nxt    = slot_r;
    cap_nxt     = cap_r;
    prod_nxt    = prod_r;
    cons_nxt    = cons_r;
    tail_nxt    = tail_r;
    walk_nxt    = walk_r;
    stop_nxt    = stop_r;
    ov_nxt      = 1'b0;
    ostat_nxt   = ostat_r;
    oidx_nxt    = oidx_r;
    owake_nxt   = owake_r;
    onotify_nxt = onotify_r;
    osync_nxt   = osync_r;
    oerr_nxt    = oerr_r;
    otail_nxt   = otail_r;
    olast_nxt   = olast_r;
    wr          = '0;
    rd_addr     = walk_r;
    alu_op      = mrde_pkg::MODE_RECLAIM;

    case (state_r)
      mrde_pkg::S_IDLE: begin
        if (cfg_we) begin
          cap_nxt  = cfg_wdata;
          prod_nxt = '0;
          cons_nxt = '0;
          tail_nxt = '0;
        end else if (start) begin
          mode_nxt   = mrde_pkg::mode_t'(in_mode);
          client_nxt = in_client_id;
          sync_nxt   = in_sync_request;
          fail_nxt   = in_fill_failed;
          slot_nxt   = in_slot;
          walk_nxt   = tail_r;
        end
      end
      mrde_pkg::S_EXEC: begin
        alu_op      = mode_r;
        ov_nxt      = 1'b1;
        olast_nxt   = 1'b1;
        owake_nxt   = '0;
        onotify_nxt = 1'b0;
        osync_nxt   = 1'b0;
        oerr_nxt    = 1'b0;
        otail_nxt   = tail_r;
        case (mode_r)
          mrde_pkg::MODE_PRODUCE: begin
            rd_addr  = prod_r;
            oidx_nxt = prod_r;
            if (prod_adv == tail_r) begin
              ostat_nxt = mrde_pkg::STAT_FULL;
            end else if (fail_r) begin
              ostat_nxt = mrde_pkg::STAT_FILL_FAILED;
            end else begin
              wr.en        = 1'b1;
              wr.addr      = prod_r;
              wr.flags     = alu.flags;
              wr.client_en = 1'b1;
              wr.client    = client_r;
              prod_nxt     = prod_adv;
              ostat_nxt    = mrde_pkg::STAT_OK;
              onotify_nxt  = 1'b1;
              osync_nxt    = sync_r;
            end
          end
          mrde_pkg::MODE_CONSUME: begin
            rd_addr  = cons_r;
            oidx_nxt = cons_r;
            if (cons_r == prod_r) begin
              ostat_nxt = mrde_pkg::STAT_EMPTY;
            end else begin
              wr.en       = alu.write;
              wr.addr     = cons_r;
              wr.flags    = alu.flags;
              cons_nxt    = mrde_pkg::next_idx(cons_r, cap_act);
              ostat_nxt   = alu.status;
              onotify_nxt = alu.sync;
              osync_nxt   = alu.sync;
            end
          end
          mrde_pkg::MODE_FINISH: begin
            rd_addr  = slot_r;
            oidx_nxt = slot_r;
            if ({1'b0, slot_r} >= cap_act) begin
              ostat_nxt = mrde_pkg::STAT_NOT_PENDING;
            end else begin
              wr.en     = alu.write;
              wr.addr   = slot_r;
              wr.flags  = alu.flags;
              ostat_nxt = alu.status;
              osync_nxt = alu.sync;
              oerr_nxt  = alu.err;
            end
          end
          default: begin
            ov_nxt = 1'b0;
          end
        endcase
      end
      mrde_pkg::S_SCAN: begin
        if (walk_done) begin
          stop_nxt = cons_r;
          walk_nxt = tail_r;
        end else if (alu.wake) begin
          stop_nxt = walk_r;
          walk_nxt = tail_r;
        end else begin
          walk_nxt = mrde_pkg::next_idx(walk_r, cap_act);
        end
      end
      mrde_pkg::S_FIX: begin
        owake_nxt   = '0;
        onotify_nxt = 1'b0;
        osync_nxt   = 1'b0;
        oerr_nxt    = 1'b0;
        otail_nxt   = stop_r;
        if (walk_done) begin
          tail_nxt  = stop_r;
          ov_nxt    = 1'b1;
          ostat_nxt = mrde_pkg::STAT_TAIL;
          oidx_nxt  = cons_r;
          olast_nxt = 1'b1;
        end else begin
          wr.en    = 1'b1;
          wr.addr  = walk_r;
          wr.flags = alu.flags;
          walk_nxt = mrde_pkg::next_idx(walk_r, cap_act);
          if (alu.wake) begin
            ov_nxt    = 1'b1;
            ostat_nxt = mrde_pkg::STAT_WAKE;
            oidx_nxt  = walk_r;
            owake_nxt = rd_client;
            olast_nxt = 1'b0;
          end
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrde_pkg::S_IDLE;
      cap_r   <= mrde_pkg::cap_t'(mrde_pkg::MAX_ENTRIES);
      prod_r  <= '0;
      cons_r  <= '0;
      tail_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      prod_r  <= prod_nxt;
      cons_r  <= cons_nxt;
      tail_r  <= tail_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    client_r  <= client_nxt;
    sync_r    <= sync_nxt;
    fail_r    <= fail_nxt;
    slot_r    <= slot_nxt;
    walk_r    <= walk_nxt;
    stop_r    <= stop_nxt;
    ostat_r   <= ostat_nxt;
    oidx_r    <= oidx_nxt;
    owake_r   <= owake_nxt;
    onotify_r <= onotify_nxt;
    osync_r   <= osync_nxt;
    oerr_r    <= oerr_nxt;
    otail_r   <= otail_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ostat_r;
  assign out_entry_index = oidx_r;
  assign out_wake_client = owake_r;
  assign out_notify_peer = onotify_r;
  assign out_sync_flag   = osync_r;
  assign out_entry_error = oerr_r;
  assign out_new_tail    = otail_r;
  assign out_last        = olast_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we |=> busy)
    else $error("request accepted but engine not busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result while engine still busy");

  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, prod_r} < cap_act) && ({1'b0, cons_r} < cap_act))
    else $error("ring head index beyond capacity");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, tail_r} < cap_act)
    else $error("reclaim tail beyond capacity");

endmodule

// ===== src/message_ring_descriptor_engine_core.sv =====
// Top level of the message ring descriptor engine.
// Instantiates mrde_seq, mrde_flag_store and mrde_flag_alu; uses mrde_pkg.
//
// A request is taken when start is high and busy and cfg_we are low; busy stays
// high until the request is done and results appear on the out_ ports, one per
// cycle marked by out_valid, with no way to stall them. Produce, consume and
// finish pass from the accept cycle to S_EXEC, which reads, updates and writes
// the entry's flags, with the result shown in the following cycle while busy is
// already low. A reclaim walks the entries between the tail and the consumer
// head twice through the single flag port: a scan that finds where the tail
// stops, then a fix pass that rewrites each entry, emits a wake result per
// waiting sync entry and ends with the tail report. Reset clears all entry
// flags at once; no clearing pass is needed. Write cfg_wdata only while idle;
// it restarts all three ring indices.
module message_ring_descriptor_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_client_id,
  input  logic       in_sync_request,
  input  logic       in_fill_failed,
  input  logic [4:0] in_slot,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [4:0] out_entry_index,
  output logic [5:0] out_wake_client,
  output logic       out_notify_peer,
  output logic       out_sync_flag,
  output logic       out_entry_error,
  output logic [4:0] out_new_tail,
  output logic       out_last
);

  mrde_pkg::idx_t     rd_addr;
  mrde_pkg::flags_t   rd_flags;
  mrde_pkg::client_t  rd_client;
  mrde_pkg::wr_req_t  wr;
  mrde_pkg::mode_t    alu_op;
  logic               alu_sync;
  mrde_pkg::alu_res_t alu_res;

  mrde_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_client_id    (in_client_id),
    .in_sync_request (in_sync_request),
    .in_fill_failed  (in_fill_failed),
    .in_slot         (in_slot),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .rd_addr         (rd_addr),
    .rd_client       (rd_client),
    .alu_op          (alu_op),
    .alu_sync        (alu_sync),
    .alu             (alu_res),
    .wr              (wr),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_wake_client (out_wake_client),
    .out_notify_peer (out_notify_peer),
    .out_sync_flag   (out_sync_flag),
    .out_entry_error (out_entry_error),
    .out_new_tail    (out_new_tail),
    .out_last        (out_last)
  );

  mrde_flag_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_flags  (rd_flags),
    .rd_client (rd_client),
    .wr        (wr)
  );

  mrde_flag_alu u_alu (
    .op       (alu_op),
    .f        (rd_flags),
    .sync_req (alu_sync),
    .res      (alu_res)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for message_ring_descriptor_engine_core: a predictor of the ring
// flags and indices queues the reports each request should produce and compares them.
// Depends on mrde_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    mrde_pkg::status_t status;
    mrde_pkg::idx_t    entry;
    mrde_pkg::client_t wake;
    logic              notify;
    logic              sync;
    logic              err;
    mrde_pkg::idx_t    tail;
    logic              last;
  } ring_report_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_mode;
  logic [5:0] in_client_id;
  logic       in_sync_request;
  logic       in_fill_failed;
  logic [4:0] in_slot;
  logic       cfg_we;
  logic [5:0] cfg_wdata;
  logic       out_valid;
  logic [2:0] out_status;
  logic [4:0] out_entry_index;
  logic [5:0] out_wake_client;
  logic       out_notify_peer;
  logic       out_sync_flag;
  logic       out_entry_error;
  logic [4:0] out_new_tail;
  logic       out_last;

  mrde_pkg::flags_t  ring_flags [mrde_pkg::MAX_ENTRIES];
  mrde_pkg::client_t ring_client [mrde_pkg::MAX_ENTRIES];
  mrde_pkg::idx_t    prod_idx;
  mrde_pkg::idx_t    cons_idx;
  mrde_pkg::idx_t    tail_idx;
  mrde_pkg::cap_t    cap_reg;
  ring_report_t      expected_reports [$];
  ring_report_t      head_report;
  int                errors;
  int                idle_pct;

  message_ring_descriptor_engine_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_client_id    (in_client_id),
    .in_sync_request (in_sync_request),
    .in_fill_failed  (in_fill_failed),
    .in_slot         (in_slot),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_wake_client (out_wake_client),
    .out_notify_peer (out_notify_peer),
    .out_sync_flag   (out_sync_flag),
    .out_entry_error (out_entry_error),
    .out_new_tail    (out_new_tail),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int usable_capacity();
    int c;
    c = int'(cap_reg);
    if (c < 2) c = 2;
    if (c > mrde_pkg::MAX_ENTRIES) c = mrde_pkg::MAX_ENTRIES;
    return c;
  endfunction

  function automatic mrde_pkg::idx_t step_index(mrde_pkg::idx_t i, int cap);
    return (int'(i) + 1 >= cap) ? mrde_pkg::idx_t'(0) : mrde_pkg::idx_t'(int'(i) + 1);
  endfunction

  function automatic ring_report_t make_report(mrde_pkg::status_t status,
                                               mrde_pkg::idx_t entry,
                                               mrde_pkg::client_t wake,
                                               logic notify, logic sync, logic err,
                                               logic last);
    ring_report_t r;
    r.status = status;
    r.entry  = entry;
    r.wake   = wake;
    r.notify = notify;
    r.sync   = sync;
    r.err    = err;
    r.tail   = tail_idx;
    r.last   = last;
    return r;
  endfunction

  function automatic void predict_request(mrde_pkg::mode_t mode, mrde_pkg::client_t client,
                                          logic sync_req, logic fill_fail,
                                          mrde_pkg::idx_t slot);
    int                cap;
    int                guard;
    mrde_pkg::idx_t    nxt;
    mrde_pkg::idx_t    idx;
    mrde_pkg::idx_t    tail;
    mrde_pkg::flags_t  f;
    logic              moving;
    mrde_pkg::status_t status;
    ring_report_t      walk [$];
    cap = usable_capacity();
    case (mode)
      mrde_pkg::MODE_PRODUCE: begin
        nxt = step_index(prod_idx, cap);
        if (nxt == tail_idx) begin
          expected_reports.push_back(make_report(mrde_pkg::STAT_FULL, prod_idx, '0,
                                                 1'b0, 1'b0, 1'b0, 1'b1));
        end else if (fill_fail) begin
          expected_reports.push_back(make_report(mrde_pkg::STAT_FILL_FAILED, prod_idx, '0,
                                                 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          f = '0;
          f[mrde_pkg::F_PEND] = 1'b1;
          if (sync_req) f[mrde_pkg::F_SYNC] = 1'b1;
          else f[mrde_pkg::F_COMP] = 1'b1;
          ring_flags[prod_idx] = f;
          ring_client[prod_idx] = client;
          expected_reports.push_back(make_report(mrde_pkg::STAT_OK, prod_idx, '0,
                                                 1'b1, sync_req, 1'b0, 1'b1));
          prod_idx = nxt;
        end
      end
      mrde_pkg::MODE_CONSUME: begin
        idx = cons_idx;
        if (idx == prod_idx) begin
          expected_reports.push_back(make_report(mrde_pkg::STAT_EMPTY, idx, '0,
                                                 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          f = ring_flags[idx];
          if (f[mrde_pkg::F_PEND]) begin
            f[mrde_pkg::F_PEND] = 1'b0;
            ring_flags[idx] = f;
            status = mrde_pkg::STAT_OK;
          end else begin
            status = mrde_pkg::STAT_NOT_PENDING;
          end
          cons_idx = step_index(idx, cap);
          expected_reports.push_back(make_report(status, idx, '0, f[mrde_pkg::F_SYNC],
                                                 f[mrde_pkg::F_SYNC], 1'b0, 1'b1));
        end
      end
      mrde_pkg::MODE_RECLAIM: begin
        idx = tail_idx;
        tail = tail_idx;
        moving = 1'b1;
        guard = 0;
        while (idx != cons_idx && guard < cap) begin
          f = ring_flags[idx];
          if (f[mrde_pkg::F_PEND]) begin
            f[mrde_pkg::F_PEND] = 1'b0;
            f[mrde_pkg::F_ERR] = 1'b1;
          end
          if (!f[mrde_pkg::F_COMP]) begin
            if (f[mrde_pkg::F_SYNC]) begin
              moving = 1'b0;
              if (walk.size() < 31)
                walk.push_back(make_report(mrde_pkg::STAT_WAKE, idx, ring_client[idx],
                                           1'b0, 1'b0, 1'b0, 1'b0));
            end else begin
              f[mrde_pkg::F_COMP] = 1'b1;
            end
          end
          ring_flags[idx] = f;
          idx = step_index(idx, cap);
          if (moving) tail = idx;
          guard++;
        end
        tail_idx = tail;
        foreach (walk[k]) begin
          walk[k].tail = tail_idx;
          expected_reports.push_back(walk[k]);
        end
        expected_reports.push_back(make_report(mrde_pkg::STAT_TAIL, cons_idx, '0,
                                               1'b0, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        if (int'(slot) >= cap) begin
          expected_reports.push_back(make_report(mrde_pkg::STAT_NOT_PENDING, slot, '0,
                                                 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          f = ring_flags[slot];
          if (f[mrde_pkg::F_PEND]) begin
            status = mrde_pkg::STAT_STILL_PENDING;
          end else begin
            f[mrde_pkg::F_COMP] = 1'b1;
            ring_flags[slot] = f;
            status = mrde_pkg::STAT_OK;
          end
          expected_reports.push_back(make_report(status, slot, '0, 1'b0, f[mrde_pkg::F_SYNC],
                                                 f[mrde_pkg::F_ERR], 1'b1));
        end
      end
    endcase
  endfunction

  function automatic mrde_pkg::idx_t waiting_sync_slot(mrde_pkg::idx_t fallback);
    mrde_pkg::idx_t idx;
    int             guard;
    idx = tail_idx;
    guard = 0;
    while (idx != cons_idx && guard < mrde_pkg::MAX_ENTRIES) begin
      if (ring_flags[idx][mrde_pkg::F_SYNC] && !ring_flags[idx][mrde_pkg::F_COMP]) return idx;
      idx = step_index(idx, usable_capacity());
      guard++;
    end
    return fallback;
  endfunction

  task automatic check_field(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d entry %0d",
                 $time, out_status, out_entry_index);
        errors++;
      end else begin
        head_report = expected_reports.pop_front();
        check_field("status", 6'(head_report.status), 6'(out_status));
        check_field("entry_index", 6'(head_report.entry), 6'(out_entry_index));
        check_field("wake_client", head_report.wake, out_wake_client);
        check_field("notify_peer", 6'(head_report.notify), 6'(out_notify_peer));
        check_field("sync_flag", 6'(head_report.sync), 6'(out_sync_flag));
        check_field("entry_error", 6'(head_report.err), 6'(out_entry_error));
        check_field("new_tail", 6'(head_report.tail), 6'(out_new_tail));
        check_field("last", 6'(head_report.last), 6'(out_last));
      end
    end
  end

  task automatic send_request(mrde_pkg::mode_t mode, mrde_pkg::client_t client,
                              logic sync_req, logic fill_fail, mrde_pkg::idx_t slot);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start           <= 1'b1;
    in_mode         <= mode;
    in_client_id    <= client;
    in_sync_request <= sync_req;
    in_fill_failed  <= fill_fail;
    in_slot         <= slot;
    do @(posedge clk); while (busy);
    predict_request(mode, client, sync_req, fill_fail, slot);
  endtask

  task automatic wait_ring_idle();
    @(negedge clk) start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(mrde_pkg::cap_t value);
    wait_ring_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cap_reg  = value;
    prod_idx = '0;
    cons_idx = '0;
    tail_idx = '0;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic send_random_request();
    int              pick;
    mrde_pkg::mode_t mode;
    mrde_pkg::idx_t  slot;
    pick = $urandom_range(99);
    slot = mrde_pkg::idx_t'($urandom_range(31));
    if (pick < 40) mode = mrde_pkg::MODE_PRODUCE;
    else if (pick < 68) mode = mrde_pkg::MODE_CONSUME;
    else if (pick < 82) mode = mrde_pkg::MODE_RECLAIM;
    else begin
      mode = mrde_pkg::MODE_FINISH;
      if ($urandom_range(3) != 0) slot = waiting_sync_slot(slot);
    end
    send_request(mode, mrde_pkg::client_t'($urandom_range(63)), 1'($urandom_range(1)),
                 $urandom_range(9) == 0, slot);
  endtask

  task automatic test_empty_ring();
    send_request(mrde_pkg::MODE_CONSUME, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_RECLAIM, 6'd63, 1'b1, 1'b1, 5'd31);
    send_request(mrde_pkg::MODE_FINISH, 6'd0, 1'b0, 1'b0, 5'd31);
  endtask

  task automatic test_minimal_ring();
    write_capacity(6'd0);
    send_request(mrde_pkg::MODE_PRODUCE, 6'd63, 1'b1, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_PRODUCE, 6'd5, 1'b0, 1'b1, 5'd0);
    send_request(mrde_pkg::MODE_FINISH, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_FINISH, 6'd0, 1'b0, 1'b0, 5'd31);
    send_request(mrde_pkg::MODE_CONSUME, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_CONSUME, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_RECLAIM, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_FINISH, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_RECLAIM, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_PRODUCE, 6'd17, 1'b1, 1'b1, 5'd0);
    send_request(mrde_pkg::MODE_PRODUCE, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_CONSUME, 6'd0, 1'b0, 1'b0, 5'd0);
    send_request(mrde_pkg::MODE_RECLAIM, 6'd0, 1'b0, 1'b0, 5'd0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(6'd63);
    send_request(mrde_pkg::MODE_PRODUCE, 6'd21, 1'b1, 1'b0, 5'd31);
    send_request(mrde_pkg::MODE_FINISH, 6'd42, 1'b1, 1'b1, 5'd31);
    write_capacity(6'd1);
    send_request(mrde_pkg::MODE_FINISH, 6'd0, 1'b0, 1'b0, 5'd2);
    write_capacity(6'd33);
    send_request(mrde_pkg::MODE_FINISH, 6'd0, 1'b0, 1'b0, 5'd31);
    send_request(mrde_pkg::MODE_PRODUCE, 6'd42, 1'b1, 1'b0, 5'd16);
  endtask

  task automatic test_random_traffic();
    mrde_pkg::cap_t caps [10];
    int             pcts [3];
    caps = '{6'd32, 6'd2, 6'd7, 6'd0, 6'd63, 6'd17, 6'd1, 6'd33, 6'd3, 6'd12};
    pcts = '{0, 73, 24};
    caps[9] = mrde_pkg::cap_t'($urandom_range(63));
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      idle_pct = pcts[p % 3];
      repeat (48) send_random_request();
    end
    idle_pct = 0;
  endtask

  initial begin
    start           = 1'b0;
    in_mode         = '0;
    in_client_id    = '0;
    in_sync_request = 1'b0;
    in_fill_failed  = 1'b0;
    in_slot         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    errors          = 0;
    idle_pct        = 0;
    foreach (ring_flags[i]) begin
      ring_flags[i]  = '0;
      ring_client[i] = '0;
    end
    prod_idx = '0;
    cons_idx = '0;
    tail_idx = '0;
    cap_reg  = mrde_pkg::cap_t'(mrde_pkg::MAX_ENTRIES);
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_empty_ring();
    test_minimal_ring();
    test_capacity_limits();
    test_random_traffic();
    wait_ring_idle();
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
